// ----- src/abpd_pkg.sv -----
// Shared types, constants and register indexes for the audio burst pulse detector.
package abpd_pkg;

   // Field widths.
   localparam int SampleW  = 10;
   localparam int IntegW   = 16;
   localparam int RunW     = 11;
   localparam int SilenceW = 16;
   localparam int WidthW   = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // Pulse width is the run count divided by eight.
   localparam int WidthShift = 3;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_THRESHOLD        = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_INTEGRATOR_LIMIT = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_INTEGRATOR_FLOOR = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_RUN_LIMIT        = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_RUN_FLOOR        = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_SILENCE_TIMEOUT  = 3'd5;

   // Register reset values.
   localparam logic [SampleW-1:0]  THRESHOLD_RST        = 10'd537;
   localparam logic [IntegW-1:0]   INTEGRATOR_LIMIT_RST = 16'd4000;
   localparam logic [IntegW-1:0]   INTEGRATOR_FLOOR_RST = 16'd200;
   localparam logic [RunW-1:0]     RUN_LIMIT_RST        = 11'd1024;
   localparam logic [RunW-1:0]     RUN_FLOOR_RST        = 11'd8;
   localparam logic [SilenceW-1:0] SILENCE_TIMEOUT_RST  = 16'd40000;

   // Largest value the silence counter can hold.
   localparam logic [SilenceW-1:0] SILENCE_MAX = {SilenceW{1'b1}};

   // Configuration register set.
   typedef struct packed {
      logic [SampleW-1:0]  threshold;
      logic [IntegW-1:0]   integrator_limit;
      logic [IntegW-1:0]   integrator_floor;
      logic [RunW-1:0]     run_limit;
      logic [RunW-1:0]     run_floor;
      logic [SilenceW-1:0] silence_timeout;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic              pulse_valid;
      logic [WidthW-1:0] burst_len;
      logic              silence_timeout_hit;
   } result_type;

endpackage

// ----- src/abpd_csr.sv -----
// Configuration register file of the audio burst pulse detector.
module abpd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [abpd_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [abpd_pkg::CsrDataW-1:0]   csr_wdata,
   output abpd_pkg::cfg_type               cfg
);

   abpd_pkg::cfg_type cfg_ff;
   abpd_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            abpd_pkg::CSR_THRESHOLD:
               cfg_in.threshold = csr_wdata[abpd_pkg::SampleW-1:0];
            abpd_pkg::CSR_INTEGRATOR_LIMIT:
               cfg_in.integrator_limit = csr_wdata[abpd_pkg::IntegW-1:0];
            abpd_pkg::CSR_INTEGRATOR_FLOOR:
               cfg_in.integrator_floor = csr_wdata[abpd_pkg::IntegW-1:0];
            abpd_pkg::CSR_RUN_LIMIT:
               cfg_in.run_limit = csr_wdata[abpd_pkg::RunW-1:0];
            abpd_pkg::CSR_RUN_FLOOR:
               cfg_in.run_floor = csr_wdata[abpd_pkg::RunW-1:0];
            abpd_pkg::CSR_SILENCE_TIMEOUT:
               cfg_in.silence_timeout = csr_wdata[abpd_pkg::SilenceW-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Register bank with its documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold        <= abpd_pkg::THRESHOLD_RST;
         cfg_ff.integrator_limit <= abpd_pkg::INTEGRATOR_LIMIT_RST;
         cfg_ff.integrator_floor <= abpd_pkg::INTEGRATOR_FLOOR_RST;
         cfg_ff.run_limit        <= abpd_pkg::RUN_LIMIT_RST;
         cfg_ff.run_floor        <= abpd_pkg::RUN_FLOOR_RST;
         cfg_ff.silence_timeout  <= abpd_pkg::SILENCE_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/abpd_core.sv -----
// Burst detection datapath: integrator, run counter and silence counter.
module abpd_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [abpd_pkg::SampleW-1:0]   sample,
   input  abpd_pkg::cfg_type              cfg,
   output abpd_pkg::result_type           result
);

   logic [abpd_pkg::IntegW-1:0]   excess_sum_ff, excess_sum_in;
   logic [abpd_pkg::RunW-1:0]     run_count_ff, run_count_in;
   logic [abpd_pkg::SilenceW-1:0] silence_count_ff, silence_count_in;

   logic                          active;
   logic [abpd_pkg::SampleW-1:0]  excess;
   logic [abpd_pkg::IntegW:0]     sum_wide;
   logic [abpd_pkg::RunW:0]       run_wide;
   logic [abpd_pkg::SilenceW-1:0] silence_inc;
   logic [abpd_pkg::SilenceW-1:0] silence_upd;
   logic                          fire;
   logic                          hit;

   // Active sample: add the excess and extend the run, both clamped to their ceilings.
   assign active   = sample > cfg.threshold;
   assign excess   = sample - cfg.threshold;
   assign sum_wide = {1'b0, excess_sum_ff}
                   + {{(abpd_pkg::IntegW + 1 - abpd_pkg::SampleW){1'b0}}, excess};
   assign run_wide = {1'b0, run_count_ff} + {{abpd_pkg::RunW{1'b0}}, 1'b1};

   // A burst qualifies on a quiet sample when both accumulators exceed their floors.
   assign fire = !active && (run_count_ff > cfg.run_floor)
                 && (excess_sum_ff > cfg.integrator_floor);

   // Quiet samples count up to the top and hold there; a pulse clears the count.
   assign silence_inc = (silence_count_ff != abpd_pkg::SILENCE_MAX)
                        ? silence_count_ff + 1'b1 : silence_count_ff;

   always_comb begin
      if (active) begin
         silence_upd = silence_count_ff;
      end else if (fire) begin
         silence_upd = '0;
      end else begin
         silence_upd = silence_inc;
      end
   end

   // The timeout check follows the update on every sample.
   assign hit = silence_upd > cfg.silence_timeout;

   // Next state of the three accumulators.
   always_comb begin
      if (active) begin
         excess_sum_in = (sum_wide > {1'b0, cfg.integrator_limit})
                         ? cfg.integrator_limit : sum_wide[abpd_pkg::IntegW-1:0];
         run_count_in  = (run_wide > {1'b0, cfg.run_limit})
                         ? cfg.run_limit : run_wide[abpd_pkg::RunW-1:0];
      end else begin
         excess_sum_in = '0;
         run_count_in  = '0;
      end
      silence_count_in = hit ? '0 : silence_upd;
   end

   // State advances once per transferred sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         excess_sum_ff    <= '0;
         run_count_ff     <= '0;
         silence_count_ff <= '0;
      end else if (step) begin
         excess_sum_ff    <= excess_sum_in;
         run_count_ff     <= run_count_in;
         silence_count_ff <= silence_count_in;
      end
   end

   // Result of this sample.
   assign result.pulse_valid         = fire;
   assign result.burst_len           = fire
      ? run_count_ff[abpd_pkg::WidthShift +: abpd_pkg::WidthW] : '0;
   assign result.silence_timeout_hit = hit;

endmodule

// ----- src/audio_burst_pulse_detector.sv -----
// Audio burst pulse detector: one sample in, one result out; a sample is taken
// into an input register, evaluated combinationally against the integrator, run
// and silence counters, and its result is held in an output register, so the
// block sustains one sample per clock while results are taken; a result passes
// through the input and output registers before it can be taken. It stalls only
// while the output register holds a result that has not been taken. The user must
// write configuration registers only while no sample is in flight; the block itself
// does not enforce this. A write takes effect on the next sample.
module audio_burst_pulse_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [abpd_pkg::SampleW-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_pulse_valid,
   output logic [abpd_pkg::WidthW-1:0]     rsp_burst_len,
   output logic                            rsp_silence_timeout_hit,
   input  logic                            csr_we,
   input  logic [abpd_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [abpd_pkg::CsrDataW-1:0]   csr_wdata
);

   abpd_pkg::cfg_type           cfg;
   abpd_pkg::result_type        result;

   logic                        in_valid_ff, in_valid_in;
   logic [abpd_pkg::SampleW-1:0] sample_ff;
   logic                        out_valid_ff, out_valid_in;
   abpd_pkg::result_type        out_ff;
   logic                        advance;

   abpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   abpd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (sample_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The held sample moves on whenever the output register is free or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_sample;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_pulse_valid         = out_ff.pulse_valid;
   assign rsp_burst_len           = out_ff.burst_len;
   assign rsp_silence_timeout_hit = out_ff.silence_timeout_hit;

`ifndef NO_ASSERTIONS
   // A pulse clears the silence counter, so it can never flag a timeout too.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.pulse_valid |-> !out_ff.silence_timeout_hit)
      else $error("pulse and timeout reported on the same sample");

   // Width is zero whenever no pulse is reported.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.pulse_valid |-> out_ff.burst_len == '0)
      else $error("nonzero pulse width without a pulse");

   // A sample that moves on always lands in the output register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost after advancing");

   // A blocked sample stays put in the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(sample_ff))
      else $error("stalled sample changed");
`endif

endmodule
